// ===== design/matrix_inverse_3x3_assert.svh =====
// assertion macros for the 3x3 inverse block
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH
`ifndef SYNTH
`define MI3_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MI3_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MI3_ASSERT_IMPL(name, ante, cons, msg)
`define MI3_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== design/mi3_pkg.sv =====
package mi3_pkg;

  localparam int NUM_ENT = 9;

  typedef logic [3:0] ent_idx_t;

  // cofactor k = a[P1]*a[Q1] - a[P2]*a[Q2], entries row-major
  localparam ent_idx_t COF_P1 [NUM_ENT] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam ent_idx_t COF_Q1 [NUM_ENT] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam ent_idx_t COF_P2 [NUM_ENT] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam ent_idx_t COF_Q2 [NUM_ENT] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

  // inverse entry (i,j) comes from cofactor (j,i)
  localparam ent_idx_t INV_SRC [NUM_ENT] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

endpackage

// ===== design/mi3_cof.sv =====
module mi3_cof
  import mi3_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [NUM_ENT-1:0][W-1:0]      in_a,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [NUM_ENT-1:0][2*W:0]      out_cof,
  output logic [2:0][W-1:0]              out_row
);

  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;

  logic [1:0] v_r;
  logic [2:0] en;
  logic [NUM_ENT-1:0][PW-1:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic [NUM_ENT-1:0][CW-1:0] cof_r, cof_nxt;
  logic [2:0][W-1:0] row0_r, row1_r;

  assign en[2]    = out_ready;
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign in_ready = en[0];

  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      pa_nxt[k] = PW'($signed(in_a[COF_P1[k]])) * PW'($signed(in_a[COF_Q1[k]]));
      pb_nxt[k] = PW'($signed(in_a[COF_P2[k]])) * PW'($signed(in_a[COF_Q2[k]]));
      cof_nxt[k] = CW'($signed(pa_r[k])) - CW'($signed(pb_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      row0_r <= in_a[2:0];
    end
    if (en[1]) begin
      cof_r  <= cof_nxt;
      row1_r <= row0_r;
    end
  end

  assign out_valid = v_r[1];
  assign out_cof   = cof_r;
  assign out_row   = row1_r;

endmodule

// ===== design/mi3_det.sv =====
module mi3_det
  import mi3_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [NUM_ENT-1:0][2*W:0]      in_cof,
  input  logic [2:0][W-1:0]              in_row,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3*W+2:0]                 out_dmag,
  output logic [NUM_ENT-1:0][2*W:0]      out_nmag,
  output logic [NUM_ENT-1:0]             out_neg,
  output logic                           out_sing
);

  localparam int CW = 2 * W + 1;
  localparam int LW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic [2:0] v_r;
  logic [3:0] en;
  logic [2:0][LW-1:0] plo_r, phi_r, plo_nxt, phi_nxt;
  logic [NUM_ENT-1:0][CW-1:0] cofa_r, cofb_r, nmag_r, nmag_nxt;
  logic signed [DW-1:0] det_r, det_nxt;
  logic [DW-1:0] dmag_r, dmag_nxt;
  logic [NUM_ENT-1:0] neg_r, neg_nxt;
  logic sing_r;

  assign en[3]    = out_ready;
  assign en[2]    = !v_r[2] || en[3];
  assign en[1]    = !v_r[1] || en[2];
  assign en[0]    = !v_r[0] || en[1];
  assign in_ready = en[0];

  // split each cofactor so every product stays near entry by entry width
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      plo_nxt[j] = LW'($signed(in_row[j])) * LW'($signed({1'b0, in_cof[j][W-1:0]}));
      phi_nxt[j] = LW'($signed(in_row[j])) * LW'($signed(in_cof[j][CW-1:W]));
    end
  end

  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (DW'($signed(phi_r[j])) <<< W) + DW'($signed(plo_r[j]));
    end
  end

  always_comb begin
    dmag_nxt = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    for (int k = 0; k < NUM_ENT; k++) begin
      nmag_nxt[k] = cofb_r[k][CW-1] ? (~cofb_r[k] + 1'b1) : cofb_r[k];
      neg_nxt[k]  = cofb_r[k][CW-1] ^ det_r[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      cofa_r <= in_cof;
    end
    if (en[1]) begin
      det_r  <= det_nxt;
      cofb_r <= cofa_r;
    end
    if (en[2]) begin
      dmag_r <= dmag_nxt;
      nmag_r <= nmag_nxt;
      neg_r  <= neg_nxt;
      sing_r <= (det_r == '0);
    end
  end

  assign out_valid = v_r[2];
  assign out_dmag  = dmag_r;
  assign out_nmag  = nmag_r;
  assign out_neg   = neg_r;
  assign out_sing  = sing_r;

endmodule

// ===== design/mi3_div.sv =====
module mi3_div
  import mi3_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [3*W+2:0]                 in_dmag,
  input  logic [NUM_ENT-1:0][2*W:0]      in_nmag,
  input  logic [NUM_ENT-1:0]             in_neg,
  input  logic                           in_sing,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [NUM_ENT-1:0][W-1:0]      out_res,
  output logic                           out_sing
);

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int XW = (CW + 2 * F > DW + W) ? CW + 2 * F : DW + W;
  localparam int NS = W + 2;
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MAX = {1'b1, {(W-1){1'b0}}};

  logic [NS-1:0] v_r;
  logic [NS:0] en;

  // stage 0 scales and checks range, stages 1..W each settle one quotient bit
  logic [NUM_ENT-1:0][XW-1:0] rem_r [W+1];
  logic [NUM_ENT-1:0][XW-1:0] rem_nxt [W+1];
  logic [NUM_ENT-1:0][W-1:0]  q_r [W+1];
  logic [NUM_ENT-1:0][W-1:0]  q_nxt [W+1];
  logic [XW-1:0]              dm_r [W+1];
  logic [XW-1:0]              dm_nxt [W+1];
  logic [NUM_ENT-1:0]         ovf_r [W+1];
  logic [NUM_ENT-1:0]         ovf_nxt [W+1];
  logic [NUM_ENT-1:0]         neg_r [W+1];
  logic [NUM_ENT-1:0]         neg_nxt [W+1];
  logic [W:0]                 sing_r, sing_nxt;
  logic [NUM_ENT-1:0][W-1:0]  res_r, res_nxt;
  logic                       rsing_r;

  always_comb begin
    en[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end
  assign in_ready = en[0];

  always_comb begin
    logic [XW-1:0] sh;
    logic [XW-1:0] top;
    top = XW'(in_dmag) << W;
    dm_nxt[0]   = XW'(in_dmag);
    neg_nxt[0]  = in_neg;
    sing_nxt[0] = in_sing;
    for (int k = 0; k < NUM_ENT; k++) begin
      rem_nxt[0][k] = XW'(in_nmag[k]) << (2 * F);
      ovf_nxt[0][k] = (rem_nxt[0][k] >= top);
      q_nxt[0][k]   = '0;
    end
    for (int s = 1; s <= W; s++) begin
      dm_nxt[s]   = dm_r[s-1];
      neg_nxt[s]  = neg_r[s-1];
      sing_nxt[s] = sing_r[s-1];
      ovf_nxt[s]  = ovf_r[s-1];
      sh = dm_r[s-1] << (W - s);
      for (int k = 0; k < NUM_ENT; k++) begin
        rem_nxt[s][k] = rem_r[s-1][k];
        q_nxt[s][k]   = q_r[s-1][k];
        if (rem_r[s-1][k] >= sh) begin
          rem_nxt[s][k]       = rem_r[s-1][k] - sh;
          q_nxt[s][k][W - s]  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      if (sing_r[W]) begin
        res_nxt[k] = '0;
      end else if (!neg_r[W][k]) begin
        res_nxt[k] = (ovf_r[W][k] || q_r[W][k][W-1]) ? POS_MAX : q_r[W][k];
      end else if (ovf_r[W][k] || (q_r[W][k] > NEG_MAX)) begin
        res_nxt[k] = NEG_MAX;
      end else begin
        res_nxt[k] = ~q_r[W][k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= W; s++) begin
      if (en[s]) begin
        rem_r[s]  <= rem_nxt[s];
        q_r[s]    <= q_nxt[s];
        dm_r[s]   <= dm_nxt[s];
        ovf_r[s]  <= ovf_nxt[s];
        neg_r[s]  <= neg_nxt[s];
        sing_r[s] <= sing_nxt[s];
      end
    end
    if (en[NS-1]) begin
      res_r   <= res_nxt;
      rsing_r <= sing_r[W];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_res   = res_r;
  assign out_sing  = rsing_r;

endmodule

// ===== design/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse by adjugate, signed fixed point (default Q16.16).
// Input channel: in_valid/in_ready with the nine entries in_a00..in_a22, row-major.
// Result channel: out_valid/out_ready with out_inv00..out_inv22 and out_singular.
// Each entry of the inverse is the transposed cofactor over the determinant,
// truncated toward zero and saturated; a zero determinant gives all-zero entries
// with out_singular set.
// The pipeline has two stages for the 2x2 products and cofactors, three for
// determinant and magnitudes, one range check, one restoring divide stage per
// quotient bit and one saturation stage.
// Throughput is one matrix per cycle while out_ready stays high; the nine
// divides run side by side in the same stage chain.
// Each stage holds its own valid bit and fills whenever it is empty, so empty
// slots close up while the receiver stalls and no item is lost or repeated.
// in_ready only drops once every stage holds an item and out_ready is low.
// Reset clears the valid bits; the data registers are not reset.
`include "matrix_inverse_3x3_assert.svh"

module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int ENTRY_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ENTRY_WIDTH-1:0] in_a00,
  input  logic [ENTRY_WIDTH-1:0] in_a01,
  input  logic [ENTRY_WIDTH-1:0] in_a02,
  input  logic [ENTRY_WIDTH-1:0] in_a10,
  input  logic [ENTRY_WIDTH-1:0] in_a11,
  input  logic [ENTRY_WIDTH-1:0] in_a12,
  input  logic [ENTRY_WIDTH-1:0] in_a20,
  input  logic [ENTRY_WIDTH-1:0] in_a21,
  input  logic [ENTRY_WIDTH-1:0] in_a22,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ENTRY_WIDTH-1:0] out_inv00,
  output logic [ENTRY_WIDTH-1:0] out_inv01,
  output logic [ENTRY_WIDTH-1:0] out_inv02,
  output logic [ENTRY_WIDTH-1:0] out_inv10,
  output logic [ENTRY_WIDTH-1:0] out_inv11,
  output logic [ENTRY_WIDTH-1:0] out_inv12,
  output logic [ENTRY_WIDTH-1:0] out_inv20,
  output logic [ENTRY_WIDTH-1:0] out_inv21,
  output logic [ENTRY_WIDTH-1:0] out_inv22,
  output logic                   out_singular
);

  localparam int W  = ENTRY_WIDTH;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic [NUM_ENT-1:0][W-1:0]  a;
  logic                       cof_valid, cof_ready;
  logic [NUM_ENT-1:0][CW-1:0] cof;
  logic [2:0][W-1:0]          row;
  logic                       det_valid, det_ready;
  logic [DW-1:0]              dmag;
  logic [NUM_ENT-1:0][CW-1:0] nmag;
  logic [NUM_ENT-1:0]         neg;
  logic                       sing;
  logic [NUM_ENT-1:0][W-1:0]  res;
  logic [NUM_ENT-1:0][W-1:0]  inv;

  assign a = {in_a22, in_a21, in_a20, in_a12, in_a11, in_a10, in_a02, in_a01, in_a00};

  mi3_cof #(.W(W)) u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_a      (a),
    .out_valid (cof_valid),
    .out_ready (cof_ready),
    .out_cof   (cof),
    .out_row   (row)
  );

  mi3_det #(.W(W)) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cof_valid),
    .in_ready  (cof_ready),
    .in_cof    (cof),
    .in_row    (row),
    .out_valid (det_valid),
    .out_ready (det_ready),
    .out_dmag  (dmag),
    .out_nmag  (nmag),
    .out_neg   (neg),
    .out_sing  (sing)
  );

  mi3_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (det_valid),
    .in_ready  (det_ready),
    .in_dmag   (dmag),
    .in_nmag   (nmag),
    .in_neg    (neg),
    .in_sing   (sing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res),
    .out_sing  (out_singular)
  );

  // transpose: inverse (i,j) takes cofactor (j,i)
  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      inv[k] = res[INV_SRC[k]];
    end
  end

  assign out_inv00 = inv[0];
  assign out_inv01 = inv[1];
  assign out_inv02 = inv[2];
  assign out_inv10 = inv[3];
  assign out_inv11 = inv[4];
  assign out_inv12 = inv[5];
  assign out_inv20 = inv[6];
  assign out_inv21 = inv[7];
  assign out_inv22 = inv[8];

  `MI3_ASSERT_IMPL(a_sing_zero, out_valid && out_singular, (out_inv00 == '0) && (out_inv01 == '0) && (out_inv02 == '0) && (out_inv10 == '0) && (out_inv11 == '0) && (out_inv12 == '0) && (out_inv20 == '0) && (out_inv21 == '0) && (out_inv22 == '0), "singular item with nonzero entry")
  `MI3_ASSERT_IMPL(a_empty_out_ready, !out_valid, in_ready, "input stalled with empty output stage")
  `MI3_ASSERT_NEXT(a_full_holds, !in_ready, out_valid, "output item dropped while pipeline full")

endmodule

// ===== bench/tb_matrix_inverse_3x3.sv =====
`timescale 1ns / 100ps

module tb_matrix_inverse_3x3;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int LATENCY = W + 7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_RANDOM = 1100;

  typedef logic signed [W-1:0] entry_t;

  typedef struct {
    entry_t inv [9];
    logic   singular;
  } inverse_t;

  class inverse_scoreboard;
    inverse_t pending [$];
    int errors;
    int checked;
    int singular_seen;
    int saturated_seen;

    function entry_t quotient_sat(logic signed [255:0] num, logic signed [255:0] det);
      logic neg;
      logic [255:0] n;
      logic [255:0] d;
      logic [255:0] q;
      logic [255:0] lim;
      neg = num[255] ^ det[255];
      n = num[255] ? -num : num;
      d = det[255] ? -det : det;
      q = (n << (2 * FB)) / d;
      lim = 256'd1 << (W - 1);
      if (!neg) begin
        if (q > lim - 1) begin
          saturated_seen++;
          q = lim - 1;
        end
        return entry_t'(q);
      end
      if (q > lim) begin
        saturated_seen++;
        q = lim;
      end
      return entry_t'(-q);
    endfunction

    function void note_matrix(entry_t a [9]);
      logic signed [255:0] e [9];
      logic signed [255:0] cof [9];
      logic signed [255:0] det;
      inverse_t r;
      int i;
      for (i = 0; i < 9; i++) e[i] = 256'(a[i]);
      cof[0] = e[4] * e[8] - e[5] * e[7];
      cof[1] = e[5] * e[6] - e[3] * e[8];
      cof[2] = e[3] * e[7] - e[4] * e[6];
      cof[3] = e[2] * e[7] - e[1] * e[8];
      cof[4] = e[0] * e[8] - e[2] * e[6];
      cof[5] = e[1] * e[6] - e[0] * e[7];
      cof[6] = e[1] * e[5] - e[2] * e[4];
      cof[7] = e[2] * e[3] - e[0] * e[5];
      cof[8] = e[0] * e[4] - e[1] * e[3];
      det = e[0] * cof[0] + e[1] * cof[1] + e[2] * cof[2];
      r.singular = (det == 0);
      for (i = 0; i < 9; i++)
        r.inv[i] = r.singular ? '0 : quotient_sat(cof[(i % 3) * 3 + i / 3], det);
      pending.push_back(r);
    endfunction

    function void check_result(inverse_t got);
      inverse_t want;
      int i;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, singular=%0b", $time, got.singular);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.singular) singular_seen++;
      if (got.singular !== want.singular) begin
        $display("%0t: singular expected %0b actual %0b", $time, want.singular,
                 got.singular);
        errors++;
      end
      for (i = 0; i < 9; i++)
        if (got.inv[i] !== want.inv[i]) begin
          $display("%0t: inv%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                   want.inv[i], got.inv[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  entry_t in_a [9];
  logic out_valid;
  logic out_ready;
  entry_t out_inv [9];
  logic out_singular;

  inverse_scoreboard sb;
  bit calm;
  bit stim_done;
  int idle_cycles;
  int sent;

  matrix_inverse_3x3 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inv00(out_inv[0]), .out_inv01(out_inv[1]), .out_inv02(out_inv[2]),
    .out_inv10(out_inv[3]), .out_inv11(out_inv[4]), .out_inv12(out_inv[5]),
    .out_inv20(out_inv[6]), .out_inv21(out_inv[7]), .out_inv22(out_inv[8]),
    .out_singular(out_singular)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function entry_t rand_entry();
    case ($urandom_range(0, 7))
      0: return entry_t'($urandom);
      1: return entry_t'($urandom_range(0, 5) << FB) * ($urandom_range(0, 1) ? -1 : 1);
      2: return entry_t'($signed($urandom_range(0, 65535)) - 32768);
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      4: return '0;
      default: return entry_t'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
    endcase
  endfunction

  // one input item: hold valid until accepted, random gap before unless calm
  // valid stays high after acceptance so back to back items need no second update
  task automatic send_matrix(entry_t m [9]);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) in_a[i] <= m[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_matrix(m);
    sent++;
  endtask

  task automatic send_random();
    entry_t m [9];
    int k;
    for (int i = 0; i < 9; i++) m[i] = rand_entry();
    k = $urandom_range(0, 9);
    // duplicate a row or column now and then so singular matrices show up
    if (k == 0) for (int j = 0; j < 3; j++) m[3 + j] = m[j];
    if (k == 1) for (int j = 0; j < 3; j++) m[3 * j + 2] = m[3 * j];
    if (k == 2) begin
      // near-identity, well conditioned
      for (int i = 0; i < 9; i++)
        m[i] = entry_t'($signed($urandom_range(0, 8191)) - 4096);
      m[0] += 32'sh10000; m[4] += 32'sh10000; m[8] += 32'sh10000;
    end
    send_matrix(m);
  endtask

  initial begin
    entry_t m [9];
    sb = new();
    calm = 1'b0;
    stim_done = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    for (int i = 0; i < 9; i++) in_a[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, scaled identity, zero, extremes, singular, tiny determinant
    m = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    send_matrix(m);
    m = '{32'sh20000, 0, 0, 0, -32'sh40000, 0, 0, 0, 32'sh8000};
    send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff};
    send_matrix(m);
    m = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = 32'sh80000000;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = 32'sh7fffffff;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = -1;
    send_matrix(m);
    m = '{32'sh7fffffff, 32'sh80000000, 1, -1, 32'sh7fffffff, 32'sh80000000,
          32'sh80000000, -1, 32'sh7fffffff};
    send_matrix(m);
    m = '{0, 32'sh10000, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
    send_matrix(m);
    m = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000, 32'sh60000,
          32'sh70000, 32'sh80000, 32'sh90000};
    send_matrix(m);
    m = '{32'sh10000, 32'sh20000, 32'sh30000, 0, 32'sh10000, 32'sh40000,
          32'sh50000, 32'sh60000, 0};
    send_matrix(m);
    m = '{32'sh55555555, 32'shaaaaaaaa, 32'sh12345678, 32'shedcba987, 32'sh0f0f0f0f,
          32'shf0f0f0f0, 32'sh33333333, 32'shcccccccc, 32'sh01010101};
    send_matrix(m);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - 150) calm = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stalls in bursts
  initial begin
    int burst;
    @(posedge rst_n);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_ready <= 1'b1;
      burst = $urandom_range(1, 30);
      repeat (burst) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    inverse_t got;
    if (rst_n && out_valid && out_ready) begin
      got.inv = out_inv;
      got.singular = out_singular;
      sb.check_result(got);
    end
  end

  // watchdog and end of run
  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, %0d results outstanding", $time, sb.pending.size());
        $display("end of test: mismatches");
        $finish;
      end
      if (stim_done && sb.pending.size() == 0) begin
        repeat (2 * LATENCY) @(posedge clk);
        $display("%0d matrices sent, %0d inverses checked, %0d singular, %0d saturated entries",
                 sent, sb.checked, sb.singular_seen, sb.saturated_seen);
        $display("errors: %0d", sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
          $display("end of test: clean");
        end else begin
          $display("end of test: mismatches");
        end
        $finish;
      end
    end
  end

endmodule
